// File: rtl/adc_average_deadband_stabiliser_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ADC_AVERAGE_DEADBAND_STABILISER_MACROS_SVH
`define ADC_AVERAGE_DEADBAND_STABILISER_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ADCAVG_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ADCAVG_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: rtl/adcavg_pkg.sv
package adcavg_pkg;

   localparam int CSR_IDX_W = 2;
   localparam int DEADBAND_W = 8;

   localparam int SAMPLES_RESET = 1;
   localparam int DEADBAND_RESET = 2;
   localparam int INVERT_RESET = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLES  = 2'd0,
      CSR_DEADBAND = 2'd1,
      CSR_INVERT   = 2'd2
   } csr_index_type;

   // Status of the serial divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: rtl/adcavg_if.sv
interface adcavg_req_if #(
   parameter int CH_W = 3,
   parameter int SAMPLE_W = 12
);
   logic                valid;
   logic                ready;
   logic [CH_W-1:0]     channel;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output channel, output sample, input ready);
   modport sink (input valid, input channel, input sample, output ready);
endinterface

interface adcavg_rsp_if #(
   parameter int CH_W = 3,
   parameter int SAMPLE_W = 12
);
   logic                valid;
   logic                ready;
   logic [CH_W-1:0]     out_channel;
   logic [SAMPLE_W-1:0] reading;
   logic                changed;

   modport source (output valid, output out_channel, output reading, output changed,
                   input ready);
   modport sink (input valid, input out_channel, input reading, input changed,
                 output ready);
endinterface

// File: rtl/adc_average_deadband_stabiliser.sv
// ADC averaging filter with deadband. Each accepted item is one converter sample
// tagged with a channel. Consecutive samples of one channel are summed; a change of
// channel before the group is full drops the partial sum and starts over with the new
// sample. Channels at or above NUM_CHANNELS are dropped without effect. When
// samples_per_reading samples are in (0 acts as 1, above MAX_AVERAGE acts as
// MAX_AVERAGE), the sum is divided by that count, truncated and clipped to full scale.
// The average replaces the channel's stored reading only if it differs by more than
// deadband; one result item then carries the channel, the stored reading (full scale
// minus it when the channel's invert_mask bit is set) and a changed flag.
// Timing: an item that does not close a group is summed as it is accepted. An item that
// closes a group starts the restoring divider, which produces one quotient bit per
// cycle; then the quotient is collected and clipped, the difference is formed, and the
// stored reading is updated and the result emitted. The emit step waits while an
// earlier result is still held and not yet taken on the result channel. No item is
// accepted during that time. Configuration writes take effect in the next cycle.
`include "adc_average_deadband_stabiliser_macros.svh"

module adc_average_deadband_stabiliser
   import adcavg_pkg::*;
#(
   parameter int NUM_CHANNELS = 7,
   parameter int SAMPLE_BITS = 12,
   parameter int MAX_AVERAGE = 64,
   localparam int CNT_W = $clog2(MAX_AVERAGE + 1),
   localparam int CSR_W = (CNT_W > DEADBAND_W)
                          ? ((CNT_W > NUM_CHANNELS) ? CNT_W : NUM_CHANNELS)
                          : ((DEADBAND_W > NUM_CHANNELS) ? DEADBAND_W : NUM_CHANNELS)
) (
   input  logic                 clock,
   input  logic                 reset,
   adcavg_req_if.sink           req_ch,
   adcavg_rsp_if.source         rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int SUM_W = SAMPLE_BITS + CNT_W;
   localparam int CMP_W = (SAMPLE_BITS > DEADBAND_W) ? SAMPLE_BITS : DEADBAND_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_CMP,
      ST_EMIT
   } state_type;

   state_type              state_ff;
   logic [CNT_W-1:0]       samples_ff;
   logic [DEADBAND_W-1:0]  deadband_ff;
   logic [NUM_CHANNELS-1:0] invert_ff;

   logic [SAMPLE_BITS-1:0] last_ff [NUM_CHANNELS];
   logic [SUM_W-1:0]       sum_ff;
   logic [CNT_W-1:0]       taken_ff;
   logic [CH_W-1:0]        group_ff;
   logic [SAMPLE_BITS-1:0] avg_ff;
   logic [SAMPLE_BITS-1:0] diff_ff;

   logic                   rsp_valid_ff;
   logic [CH_W-1:0]        rsp_channel_ff;
   logic [SAMPLE_BITS-1:0] rsp_reading_ff;
   logic                   rsp_changed_ff;

   logic [CNT_W-1:0]       eff_cnt;
   logic                   accept;
   logic                   ch_ok;
   logic                   restart;
   logic [SUM_W-1:0]       sum_in;
   logic [CNT_W-1:0]       taken_in;
   logic                   complete;
   logic                   div_start;
   logic [SUM_W-1:0]       quotient;
   div_stat_type           div_stat;
   logic [SAMPLE_BITS-1:0] prev;
   logic                   changed;
   logic [SAMPLE_BITS-1:0] stored;
   logic                   emit_go;

   // Clamp the programmed count into the supported range.
   always_comb begin
      eff_cnt = samples_ff;
      if (samples_ff == '0) begin
         eff_cnt = CNT_W'(1);
      end else if (samples_ff > CNT_W'(MAX_AVERAGE)) begin
         eff_cnt = CNT_W'(MAX_AVERAGE);
      end
   end

   // Accumulate path for an accepted item.
   always_comb begin
      accept   = req_ch.valid && req_ch.ready;
      ch_ok    = {1'b0, req_ch.channel} < (CH_W + 1)'(NUM_CHANNELS);
      restart  = (taken_ff != '0) && (req_ch.channel != group_ff);
      sum_in   = (restart ? '0 : sum_ff) + SUM_W'(req_ch.sample);
      taken_in = (restart ? '0 : taken_ff) + 1'b1;
      complete = taken_in >= eff_cnt;
      div_start = accept && ch_ok && complete;
   end

   // Deadband decision and output formatting for the closing group.
   always_comb begin
      prev    = last_ff[group_ff];
      changed = CMP_W'(diff_ff) > CMP_W'(deadband_ff);
      stored  = changed ? avg_ff : prev;
      emit_go = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);
   end

   adcavg_div #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (eff_cnt),
      .quotient (quotient),
      .stat     (div_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         samples_ff   <= CNT_W'(SAMPLES_RESET);
         deadband_ff  <= DEADBAND_W'(DEADBAND_RESET);
         invert_ff    <= NUM_CHANNELS'(INVERT_RESET);
         sum_ff       <= '0;
         taken_ff     <= '0;
         group_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            last_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SAMPLES:  samples_ff  <= csr_data[CNT_W-1:0];
               CSR_DEADBAND: deadband_ff <= csr_data[DEADBAND_W-1:0];
               CSR_INVERT:   invert_ff   <= csr_data[NUM_CHANNELS-1:0];
               default:      ;
            endcase
         end

         // drop the result once it is taken, unless a new one replaces it
         if (rsp_valid_ff && rsp_ch.ready && !emit_go) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept && ch_ok) begin
                  group_ff <= req_ch.channel;
                  if (complete) begin
                     sum_ff   <= '0;
                     taken_ff <= '0;
                     state_ff <= ST_DIV;
                  end else begin
                     sum_ff   <= sum_in;
                     taken_ff <= taken_in;
                  end
               end
            end
            ST_DIV: begin
               // clip the quotient to full scale
               if (div_stat.done) begin
                  avg_ff   <= (|quotient[SUM_W-1:SAMPLE_BITS]) ? '1
                              : quotient[SAMPLE_BITS-1:0];
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               diff_ff  <= (avg_ff > prev) ? (avg_ff - prev) : (prev - avg_ff);
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               // hold until the result slot is free
               if (emit_go) begin
                  if (changed) begin
                     last_ff[group_ff] <= avg_ff;
                  end
                  rsp_valid_ff   <= 1'b1;
                  rsp_channel_ff <= group_ff;
                  rsp_reading_ff <= invert_ff[group_ff] ? ~stored : stored;
                  rsp_changed_ff <= changed;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_channel = rsp_channel_ff;
   assign rsp_ch.reading     = rsp_reading_ff;
   assign rsp_ch.changed     = rsp_changed_ff;

   `ADCAVG_ASSERT_ALWAYS(a_taken_range, clock, reset, taken_ff < CNT_W'(MAX_AVERAGE),
      "partial group count reached the averaging limit")
   `ADCAVG_ASSERT_IMPLIES(a_div_owner, clock, reset, div_stat.busy || div_stat.done,
      state_ff == ST_DIV, "divider active outside the divide step")
   `ADCAVG_ASSERT_IMPLIES(a_rsp_source, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == ST_EMIT, "result raised without an emit step")
   `ADCAVG_ASSERT_IMPLIES(a_group_idle, clock, reset, state_ff != ST_IDLE,
      taken_ff == '0, "partial sum kept while a group closes")

endmodule

// File: rtl/adcavg_div.sv
// Restoring divider, one quotient bit per cycle.
module adcavg_div
   import adcavg_pkg::*;
#(
   parameter int DVD_W = 19,
   parameter int DVS_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DVD_W-1:0] quotient,
   output div_stat_type     stat
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DVS_W:0]    rem_sh;
   logic [DVS_W:0]    rem_sub;
   logic              fits;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      fits    = rem_sh >= {1'b0, dvs_ff};
      rem_in  = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      dvd_in  = {dvd_ff[DVD_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            dvd_ff  <= dividend;
            dvs_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            dvd_ff  <= dvd_in;
            rem_ff  <= rem_in;
            step_ff <= step_ff + 1'b1;
            // finish on the last quotient bit
            if (step_ff == STEP_W'(DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient  = dvd_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: tb/sv/adc_average_deadband_stabiliser_tb.sv
module adc_average_deadband_stabiliser_tb;
   import adcavg_pkg::*;

   localparam int NUM_CH = 7;
   localparam int SAMPLE_W = 12;
   localparam int MAX_AVG = 64;
   localparam int CSR_W = 8;
   localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;
   // Cycles to let a closing item finish its divide before touching the registers.
   localparam int SETTLE_CYCLES = 40;
   // Cycles the receiver holds off in the long stall.
   localparam int LONG_STALL = 300;
   // Cycles with no item moving on either channel before the run is called hung.
   localparam int STUCK_LIMIT = 3000;

   typedef struct packed {
      logic [2:0]          ch;
      logic [SAMPLE_W-1:0] smp;
   } adc_sample_type;

   typedef struct packed {
      logic [2:0]          ch;
      logic [SAMPLE_W-1:0] reading;
      logic                changed;
   } stab_reading_type;

   logic clock;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [CSR_W-1:0] csr_data;

   adcavg_req_if #(.CH_W(3), .SAMPLE_W(SAMPLE_W)) req_if ();
   adcavg_rsp_if #(.CH_W(3), .SAMPLE_W(SAMPLE_W)) rsp_if ();

   adc_average_deadband_stabiliser #(
      .NUM_CHANNELS(NUM_CH),
      .SAMPLE_BITS(SAMPLE_W),
      .MAX_AVERAGE(MAX_AVG)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Shadow copy of the configuration registers, at their reset values.
   logic [6:0] cfg_count = 7'(SAMPLES_RESET);
   logic [7:0] cfg_band = 8'(DEADBAND_RESET);
   logic [6:0] cfg_invert = 7'(INVERT_RESET);

   // Predictor state: stored reading per channel and the group being summed.
   logic [SAMPLE_W-1:0] held_reading [NUM_CH] = '{default: '0};
   logic [17:0]         group_sum = '0;
   logic [6:0]          group_taken = '0;
   logic [2:0]          group_chan = '0;

   adc_sample_type   pending_samples [$];
   stab_reading_type expected_readings [$];

   int samples_queued = 0;
   int samples_accepted = 0;
   int mismatches = 0;
   int stuck_cycles = 0;

   // Stimulus shaping: knobs set by the sequence, and the gap and stall state of driver and receiver.
   logic idle_on = 1'b1;
   int   stall_asks = 0;
   int   stalls_served;
   int   stall_left;
   int   req_gap;
   int   rsp_gap;

   adc_sample_type   next_item;
   stab_reading_type want;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Fold one accepted sample into the group; when the group closes, divide,
   // apply the deadband to the stored reading and queue the reading it emits.
   task automatic fold_sample(input logic [2:0] ch, input logic [SAMPLE_W-1:0] smp);
      logic [6:0]          n;
      logic [17:0]         avg;
      logic [SAMPLE_W-1:0] prev;
      logic [SAMPLE_W-1:0] delta;
      stab_reading_type    r;
      // Channels past the last one leave everything untouched.
      if (ch >= NUM_CH) return;
      // A channel change before the group is full drops the partial sum.
      if (group_taken != 0 && ch != group_chan) begin
         group_sum = '0;
         group_taken = '0;
      end
      group_chan = ch;
      group_sum = group_sum + smp;
      group_taken = group_taken + 7'd1;
      // A count of zero acts as one; anything above the maximum saturates.
      n = (cfg_count == 0) ? 7'd1 : ((cfg_count > MAX_AVG) ? 7'(MAX_AVG) : cfg_count);
      if (group_taken < n) return;
      // A count lowered mid-group can leave more samples than the divisor: clip.
      avg = group_sum / n;
      if (avg > FULL_SCALE) avg = 18'(FULL_SCALE);
      group_sum = '0;
      group_taken = '0;
      prev = held_reading[ch];
      delta = (avg[SAMPLE_W-1:0] > prev) ? avg[SAMPLE_W-1:0] - prev
                                         : prev - avg[SAMPLE_W-1:0];
      r.changed = (delta > cfg_band);
      if (r.changed) held_reading[ch] = avg[SAMPLE_W-1:0];
      r.ch = ch;
      r.reading = cfg_invert[ch] ? FULL_SCALE - held_reading[ch] : held_reading[ch];
      expected_readings.push_back(r);
   endtask

   // Driver: offer items from the pending queue, with random idle bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.channel <= '0;
         req_if.sample <= '0;
         req_gap <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            fold_sample(req_if.channel, req_if.sample);
            samples_accepted = samples_accepted + 1;
         end
         // Only move on once the current item is gone; hold it otherwise.
         if (!req_if.valid || req_if.ready) begin
            if (req_gap != 0) begin
               req_gap <= req_gap - 1;
               req_if.valid <= 1'b0;
            end else if (pending_samples.size() == 0) begin
               req_if.valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
               req_gap <= $urandom_range(0, 5);
               req_if.valid <= 1'b0;
            end else begin
               next_item = pending_samples.pop_front();
               req_if.valid <= 1'b1;
               req_if.channel <= next_item.ch;
               req_if.sample <= next_item.smp;
            end
         end
      end
   end

   // Receiver: check each reading against the oldest expectation and
   // stall in random bursts, or for one long stretch when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_gap <= 0;
         stall_left <= 0;
         stalls_served <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_readings.size() == 0) begin
               $error("reading with none expected: out_channel %0d reading %0d changed %0d",
                      rsp_if.out_channel, rsp_if.reading, rsp_if.changed);
               mismatches++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_if.out_channel !== want.ch) begin
                  $error("out_channel: expected %0d, got %0d", want.ch, rsp_if.out_channel);
                  mismatches++;
               end
               if (rsp_if.reading !== want.reading) begin
                  $error("reading: expected %0d, got %0d", want.reading, rsp_if.reading);
                  mismatches++;
               end
               if (rsp_if.changed !== want.changed) begin
                  $error("changed: expected %0d, got %0d", want.changed, rsp_if.changed);
                  mismatches++;
               end
            end
         end
         if (stall_asks != stalls_served) begin
            stalls_served <= stall_asks;
            stall_left <= LONG_STALL;
            rsp_if.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_if.ready <= 1'b0;
         end else if (rsp_gap != 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_if.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_gap <= $urandom_range(0, 5);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Watchdog: give up when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles == STUCK_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Write one register while the block is idle and mirror it in the shadow.
   task automatic write_csr(input csr_index_type idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SAMPLES:  cfg_count = val[6:0];
         CSR_DEADBAND: cfg_band = val[7:0];
         CSR_INVERT:   cfg_invert = val[6:0];
         default:      ;
      endcase
      @(negedge clock);
   endtask

   task automatic queue_sample(input logic [2:0] ch, input int smp);
      adc_sample_type s;
      s.ch = ch;
      s.smp = smp[SAMPLE_W-1:0];
      pending_samples.push_back(s);
      samples_queued++;
   endtask

   // Hold off the sender until every item is taken and every reading is back,
   // then give the divider time to finish any item that closes a group.
   task automatic settle();
      do @(negedge clock);
      while (samples_accepted != samples_queued || expected_readings.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Queue whole groups with random content on random channels, with some
   // short groups and stray out-of-range channels mixed in.
   task automatic queue_phase(input int budget);
      int added;
      int n;
      int len;
      int base;
      int smp;
      logic [2:0] ch;
      added = 0;
      n = (cfg_count == 0) ? 1 : ((cfg_count > MAX_AVG) ? MAX_AVG : int'(cfg_count));
      while (added < budget) begin
         ch = 3'($urandom_range(0, NUM_CH - 1));
         if ($urandom_range(0, 15) == 0) ch = 3'd7;
         len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, n)) : n;
         case ($urandom_range(0, 3))
            0: base = $urandom_range(0, 4095);
            1: base = $urandom_range(0, 1) ? 4095 : 0;
            default: begin
               // Land near the stored reading so the deadband edge gets hit.
               if (ch < NUM_CH)
                  base = int'(held_reading[ch]) + int'($urandom_range(0, 2 * cfg_band + 2))
                         - int'(cfg_band) - 1;
               else
                  base = $urandom_range(0, 4095);
            end
         endcase
         for (int i = 0; i < len; i++) begin
            smp = base;
            if ($urandom_range(0, 3) == 0) smp = base + int'($urandom_range(0, 6)) - 3;
            if (smp < 0) smp = 0;
            if (smp > 4095) smp = 4095;
            queue_sample(ch, smp);
         end
         if (ch < NUM_CH) added += len;
      end
   endtask

   initial begin
      int cnt;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_SAMPLES;
      csr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset configuration: one sample per reading, deadband 2, channel 5 inverted.
      queue_sample(3'd0, 4095);   // full scale from zero: update
      queue_sample(3'd0, 4093);   // change equal to the deadband: hold
      queue_sample(3'd0, 4092);   // one past the deadband: update
      queue_sample(3'd5, 0);      // inverted channel, no change
      queue_sample(3'd5, 4095);   // inverted channel, update
      queue_sample(3'd7, 1234);   // channel past the last: dropped
      queue_sample(3'd6, 12'hAAA);
      queue_sample(3'd3, 12'h555);
      settle();

      // Groups of four, no deadband, every channel inverted.
      write_csr(CSR_SAMPLES, 8'd4);
      write_csr(CSR_DEADBAND, 8'd0);
      write_csr(CSR_INVERT, 8'd127);
      queue_sample(3'd1, 4095);
      queue_sample(3'd1, 4095);
      queue_sample(3'd2, 4095);   // channel change drops the partial sum
      queue_sample(3'd2, 4095);
      queue_sample(3'd2, 4095);
      queue_sample(3'd2, 4095);
      queue_sample(3'd4, 1);      // average 10 / 4 truncates to 2
      queue_sample(3'd4, 2);
      queue_sample(3'd4, 3);
      queue_sample(3'd4, 4);
      settle();

      // Lower the count mid-group: seven samples divided by two clip to full scale.
      write_csr(CSR_SAMPLES, 8'd8);
      write_csr(CSR_DEADBAND, 8'd255);
      write_csr(CSR_INVERT, 8'd0);
      for (int i = 0; i < 6; i++) queue_sample(3'd6, 4095);
      settle();
      write_csr(CSR_SAMPLES, 8'd2);
      queue_sample(3'd6, 4095);
      settle();

      // Random phases, each with its own configuration.
      for (int ph = 0; samples_queued < 420; ph++) begin
         case ($urandom_range(0, 11))
            0: cnt = 0;
            1: cnt = 127;
            2: cnt = 64;
            3: cnt = 65;
            4: cnt = $urandom_range(5, 20);
            default: cnt = $urandom_range(1, 4);
         endcase
         // Keep the phase ahead of the long stall fast so the block backs up.
         if (ph == 1) cnt = 1;
         write_csr(CSR_SAMPLES, 8'(cnt));
         case ($urandom_range(0, 5))
            0: write_csr(CSR_DEADBAND, 8'd0);
            1: write_csr(CSR_DEADBAND, 8'd255);
            default: write_csr(CSR_DEADBAND, 8'($urandom_range(0, 40)));
         endcase
         case ($urandom_range(0, 5))
            0: write_csr(CSR_INVERT, 8'd0);
            1: write_csr(CSR_INVERT, 8'd127);
            default: write_csr(CSR_INVERT, 8'($urandom_range(0, 127)));
         endcase
         idle_on = ($urandom_range(0, 3) != 0);
         if (ph == 1) stall_asks++;
         queue_phase(30);
         settle();
      end

      // Last stretch at full rate on both sides.
      idle_on = 1'b0;
      write_csr(CSR_SAMPLES, 8'd2);
      write_csr(CSR_DEADBAND, 8'd3);
      write_csr(CSR_INVERT, 8'($urandom_range(0, 127)));
      queue_phase(30);
      settle();

      if (mismatches == 0 && expected_readings.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
